### hdl/rtld_pkg.sv
// ----------------------------------------------------------------------------
// rtld_pkg
// Shared types and constants for the run-length tile layer decoder.
// ----------------------------------------------------------------------------
package rtld_pkg;

	localparam int DimW   = 7;
	localparam int TileW  = 14;
	localparam int ByteW  = 8;
	localparam int DivSteps = TileW;
	localparam int CntW   = $clog2(DivSteps);

	localparam logic [ByteW-1:0] EscByte  = 8'hFF;
	localparam logic [ByteW-1:0] LayerMax = 8'hFF;

	typedef enum logic [2:0] {
		PH_ROWS  = 3'd0,
		PH_COLS  = 3'd1,
		PH_TILE  = 3'd2,
		PH_COUNT = 3'd3,
		PH_VALUE = 3'd4,
		PH_DROP  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_DIV  = 2'd2
	} seq_state_t;

	typedef struct packed {
		logic [TileW-1:0] diff;
		logic             borrow;
	} sub_res_t;

endpackage

### hdl/rle_tile_layer_decoder.sv
// ----------------------------------------------------------------------------
// rle_tile_layer_decoder
// Decodes run-length coded tile layers into run descriptors, one byte a beat.
// ----------------------------------------------------------------------------
// A descriptor is registered on the output by the execute step of its byte, which
// waits while an earlier descriptor is still held there by out_ready low.
// A byte that advances the tile position runs the 14 restoring division steps on
// the shared subtractor before the next byte is taken; other bytes do not divide.
// Reset: arst_n clears the sequencer and parse state at once; no clearing pass.
module rle_tile_layer_decoder #(
	parameter int DIM_MAX = 127
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        layer_number,
	output logic [6:0]        first_row,
	output logic [6:0]        first_col,
	output logic [7:0]        run_length,
	output logic signed [7:0] tile_value
);

	localparam int DW = rtld_pkg::DimW;
	localparam int TW = rtld_pkg::TileW;
	localparam int BW = rtld_pkg::ByteW;
	localparam logic [BW-1:0] DimLimit = BW'(DIM_MAX);

	rtld_pkg::seq_state_t state_q, state_d;
	rtld_pkg::phase_t     phase_q, phase_d;

	logic [BW-1:0] byte_q;
	logic          last_q;
	logic [DW-1:0] row_count_q, row_count_d;
	logic [DW-1:0] col_count_q, col_count_d;
	logic [TW-1:0] total_q, total_d;
	logic [BW-1:0] pending_q, pending_d;
	logic [DW-1:0] cur_row_q, cur_row_d;
	logic [DW-1:0] cur_col_q, cur_col_d;
	logic [TW-1:0] tiles_q, tiles_d;
	logic [BW-1:0] layer_q, layer_d;
	logic [TW-1:0] dvd_q;
	logic [TW-1:0] rem_q;
	logic [rtld_pkg::CntW-1:0] cnt_q;

	logic          out_valid_q;
	logic [BW-1:0] out_layer_q;
	logic [DW-1:0] out_row_q;
	logic [DW-1:0] out_col_q;
	logic [BW-1:0] out_len_q;
	logic [BW-1:0] out_value_q;

	logic [TW-1:0] eff_tiles;
	logic [BW-1:0] eff_layer;
	logic [DW-1:0] eff_row;
	logic [DW-1:0] eff_col;
	logic          emit_req;
	logic [BW-1:0] run_count;
	logic [BW-1:0] len;
	logic          emit;
	logic          exec_go;
	logic          start_div;
	logic [TW-1:0] new_tiles;
	logic [BW-1:0] layer_inc;
	logic [DW-1:0] dim_byte;

	logic [TW-1:0]      sub_a, sub_b, trial;
	rtld_pkg::sub_res_t sub_res;
	logic [TW-1:0]      rem_next;
	logic [TW-1:0]      dvd_next;

	rtld_sub u_sub (
		.a   (sub_a),
		.b   (sub_b),
		.res (sub_res)
	);

	assign in_ready  = (state_q == rtld_pkg::ST_IDLE);
	assign layer_inc = (layer_q == rtld_pkg::LayerMax) ? layer_q : layer_q + 8'd1;
	assign dim_byte  = (byte_q <= DimLimit) ? byte_q[DW-1:0] : '0;

	// Position and count that the byte works on, after any layer change.
	always_comb begin
		eff_tiles = tiles_q;
		eff_layer = layer_q;
		eff_row   = cur_row_q;
		eff_col   = cur_col_q;
		emit_req  = 1'b0;
		run_count = 8'd1;
		case (phase_q)
			rtld_pkg::PH_TILE: begin
				if (tiles_q >= total_q) begin
					eff_tiles = '0;
					eff_layer = layer_inc;
					eff_row   = '0;
					eff_col   = '0;
				end
				emit_req = (byte_q != rtld_pkg::EscByte);
			end
			rtld_pkg::PH_COUNT: begin
				if (last_q) begin
					eff_tiles = '0;
					eff_layer = layer_inc;
					eff_row   = '0;
					eff_col   = '0;
					emit_req  = (byte_q != rtld_pkg::EscByte);
				end
			end
			rtld_pkg::PH_VALUE: begin
				emit_req  = 1'b1;
				run_count = pending_q;
			end
			default: begin
			end
		endcase
	end

	assign trial = {rem_q[TW-2:0], dvd_q[TW-1]};
	assign sub_a = (state_q == rtld_pkg::ST_DIV) ? trial : total_q;
	assign sub_b = (state_q == rtld_pkg::ST_DIV) ? {{(TW-DW){1'b0}}, row_count_q} : eff_tiles;

	assign len       = ({{(TW-BW){1'b0}}, run_count} < sub_res.diff) ? run_count
	                   : sub_res.diff[BW-1:0];
	assign emit      = emit_req && (len != '0);
	assign exec_go   = !(emit && out_valid_q && !out_ready);
	assign new_tiles = eff_tiles + {{(TW-BW){1'b0}}, len};
	assign start_div = (state_q == rtld_pkg::ST_EXEC) && exec_go && emit && !last_q;

	assign rem_next = sub_res.borrow ? trial : sub_res.diff;
	assign dvd_next = {dvd_q[TW-2:0], !sub_res.borrow};

	// Next parse state for the byte being executed.
	always_comb begin
		phase_d     = phase_q;
		row_count_d = row_count_q;
		col_count_d = col_count_q;
		total_d     = total_q;
		pending_d   = pending_q;
		cur_row_d   = cur_row_q;
		cur_col_d   = cur_col_q;
		tiles_d     = tiles_q;
		layer_d     = layer_q;
		if (state_q == rtld_pkg::ST_EXEC) begin
			case (phase_q)
				rtld_pkg::PH_ROWS: begin
					row_count_d = dim_byte;
					phase_d     = rtld_pkg::PH_COLS;
				end
				rtld_pkg::PH_COLS: begin
					col_count_d = dim_byte;
					total_d     = {{(TW-DW){1'b0}}, row_count_q} *
					              {{(TW-DW){1'b0}}, dim_byte};
					if (row_count_q == '0 || dim_byte == '0) begin
						phase_d = rtld_pkg::PH_DROP;
					end else begin
						phase_d   = rtld_pkg::PH_TILE;
						layer_d   = '0;
						tiles_d   = '0;
						cur_row_d = '0;
						cur_col_d = '0;
					end
				end
				rtld_pkg::PH_TILE: begin
					layer_d   = eff_layer;
					tiles_d   = emit ? new_tiles : eff_tiles;
					cur_row_d = eff_row;
					cur_col_d = eff_col;
					if (!emit_req) begin
						phase_d = rtld_pkg::PH_COUNT;
					end
				end
				rtld_pkg::PH_COUNT: begin
					if (!last_q) begin
						pending_d = byte_q;
						phase_d   = rtld_pkg::PH_VALUE;
					end
				end
				rtld_pkg::PH_VALUE: begin
					tiles_d   = emit ? new_tiles : tiles_q;
					pending_d = '0;
					phase_d   = rtld_pkg::PH_TILE;
				end
				default: begin
				end
			endcase
			if (last_q) begin
				phase_d     = rtld_pkg::PH_ROWS;
				row_count_d = '0;
				col_count_d = '0;
				total_d     = '0;
				pending_d   = '0;
				cur_row_d   = '0;
				cur_col_d   = '0;
				tiles_d     = '0;
				layer_d     = '0;
			end
		end else if (state_q == rtld_pkg::ST_DIV &&
				cnt_q == rtld_pkg::CntW'(rtld_pkg::DivSteps - 1)) begin
			cur_row_d = rem_next[DW-1:0];
			cur_col_d = dvd_next[DW-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rtld_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = rtld_pkg::ST_EXEC;
				end
			end
			rtld_pkg::ST_EXEC: begin
				if (exec_go) begin
					state_d = start_div ? rtld_pkg::ST_DIV : rtld_pkg::ST_IDLE;
				end
			end
			rtld_pkg::ST_DIV: begin
				if (cnt_q == rtld_pkg::CntW'(rtld_pkg::DivSteps - 1)) begin
					state_d = rtld_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rtld_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rtld_pkg::ST_IDLE;
			phase_q     <= rtld_pkg::PH_ROWS;
			row_count_q <= '0;
			col_count_q <= '0;
			total_q     <= '0;
			pending_q   <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			tiles_q     <= '0;
			layer_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != rtld_pkg::ST_EXEC || exec_go) begin
				phase_q     <= phase_d;
				row_count_q <= row_count_d;
				col_count_q <= col_count_d;
				total_q     <= total_d;
				pending_q   <= pending_d;
				cur_row_q   <= cur_row_d;
				cur_col_q   <= cur_col_d;
				tiles_q     <= tiles_d;
				layer_q     <= layer_d;
			end
			if (start_div) begin
				cnt_q <= '0;
			end else if (state_q == rtld_pkg::ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == rtld_pkg::ST_EXEC && exec_go && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_q <= data_byte;
			last_q <= last_byte;
		end
		if (start_div) begin
			dvd_q <= new_tiles;
			rem_q <= '0;
		end else if (state_q == rtld_pkg::ST_DIV) begin
			dvd_q <= dvd_next;
			rem_q <= rem_next;
		end
		if (state_q == rtld_pkg::ST_EXEC && exec_go && emit) begin
			out_layer_q <= eff_layer;
			out_row_q   <= eff_row;
			out_col_q   <= eff_col;
			out_len_q   <= len;
			out_value_q <= byte_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign layer_number = out_layer_q;
	assign first_row    = out_row_q;
	assign first_col    = out_col_q;
	assign run_length   = out_len_q;
	assign tile_value   = $signed(out_value_q);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("decoder ready right after taking a beat");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rtld_pkg::ST_IDLE && (phase_q == rtld_pkg::PH_TILE ||
		 phase_q == rtld_pkg::PH_COUNT || phase_q == rtld_pkg::PH_VALUE))
		|-> (cur_row_q < row_count_q))
		else $error("current row not below row count");

	a_out_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == rtld_pkg::ST_EXEC))
		else $error("descriptor raised outside execute step");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rtld_pkg::ST_DIV) |-> (cnt_q < rtld_pkg::CntW'(rtld_pkg::DivSteps)))
		else $error("division step counter overran");
`endif

endmodule

### hdl/rtld_sub.sv
// ----------------------------------------------------------------------------
// rtld_sub
// Shared subtractor used for the layer remainder and for every division step.
// ----------------------------------------------------------------------------
module rtld_sub (
	input  logic [rtld_pkg::TileW-1:0] a,
	input  logic [rtld_pkg::TileW-1:0] b,
	output rtld_pkg::sub_res_t         res
);

	logic [rtld_pkg::TileW:0] full;

	assign full       = {1'b0, a} - {1'b0, b};
	assign res.diff   = full[rtld_pkg::TileW-1:0];
	assign res.borrow = full[rtld_pkg::TileW];

endmodule
